### sv/cbd_pkg.sv
// Shared types and constants for the CPU bus decoder with sprite DMA.
`default_nettype none
package cbd_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    localparam logic [15:0] RAM_LAST_ADDR = 16'h1FFF;
    localparam logic [15:0] PPU_LAST_ADDR = 16'h3FFF;
    localparam logic [15:0] DMA_REG_ADDR  = 16'h4014;
    localparam logic [15:0] PAD0_ADDR     = 16'h4016;
    localparam logic [15:0] PAD1_ADDR     = 16'h4017;
    localparam logic [2:0]  PHASE_READ    = 3'd0;
    localparam logic [2:0]  PHASE_WRITE   = 3'd3;
    localparam logic [2:0]  PHASE_LAST    = 3'd5;
    localparam logic [7:0]  DMA_LAST_IDX  = 8'hFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        peek_only;
        logic        cart_claims;
        logic [7:0]  cart_read_data;
        logic [7:0]  ppu_read_data;
        logic [7:0]  pad0_buttons;
        logic [7:0]  pad1_buttons;
        logic        ppu_nmi_request;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_result;
        logic        ppu_select;
        logic [2:0]  ppu_register;
        logic        cpu_step;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic [7:0]  oam_data;
        logic        dma_active;
        logic [15:0] dma_source;
        logic        cpu_nmi;
        logic        ram_hit;
    } t_result;

    typedef struct packed {
        logic        wr;
        logic        rd;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_ram_req;

endpackage
`default_nettype wire

### sv/cbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### sv/cbd_clear.sv
// Post-reset sweep that zeroes every work RAM entry.
`default_nettype none
module cbd_clear #(
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    output logic                          o_busy,
    output logic      [$clog2(DEPTH)-1:0] o_addr
);

    localparam int AW = $clog2(DEPTH);

    logic          r_busy;
    logic [AW-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else if (r_busy) begin
            r_addr <= r_addr + AW'(1);
            if (r_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_addr = r_addr;

endmodule
`default_nettype wire

### sv/cbd_core.sv
// Bus decode, pad shifters, tick phase and sprite DMA sequencing for one beat.
`default_nettype none
module cbd_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire cbd_pkg::t_item   i_item,
    input  wire logic [7:0]       i_ram_rdata,
    output cbd_pkg::t_result      o_res,
    output cbd_pkg::t_ram_req     o_ram
);

    logic [7:0] r_pad [2];
    logic [7:0] n_pad [2];
    logic [7:0] r_page, n_page;
    logic [7:0] r_index, n_index;
    logic [7:0] r_byte, n_byte;
    logic       r_running, n_running;
    logic       r_align, n_align;
    logic [2:0] r_phase, n_phase;
    logic       r_cap, n_cap;

    logic        rd_en;
    logic [15:0] rd_addr;
    logic [7:0]  rd_data;
    logic        dma_fetch;
    logic        pidx;

    always_comb begin
        o_res     = '0;
        o_ram     = '0;
        n_pad     = r_pad;
        n_page    = r_page;
        n_index   = r_index;
        n_byte    = r_byte;
        n_running = r_running;
        n_align   = r_align;
        n_phase   = r_phase;
        n_cap     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = i_item.address;
        rd_data   = '0;
        dma_fetch = 1'b0;
        pidx      = i_item.address[0];

        case (cbd_pkg::t_cmd'(i_item.command))
            cbd_pkg::CMD_READ: begin
                rd_en = 1'b1;
            end
            cbd_pkg::CMD_WRITE: begin
                if (!i_item.cart_claims) begin
                    if (i_item.address inside {[16'h0000:cbd_pkg::RAM_LAST_ADDR]}) begin
                        o_ram.wr    = 1'b1;
                        o_ram.addr  = i_item.address;
                        o_ram.wdata = i_item.write_data;
                    end else if (i_item.address <= cbd_pkg::PPU_LAST_ADDR) begin
                        o_res.ppu_select   = 1'b1;
                        o_res.ppu_register = i_item.address[2:0];
                    end else if (i_item.address == cbd_pkg::DMA_REG_ADDR) begin
                        n_page    = i_item.write_data;
                        n_index   = '0;
                        n_running = 1'b1;
                    end else if (i_item.address inside
                                 {cbd_pkg::PAD0_ADDR, cbd_pkg::PAD1_ADDR}) begin
                        n_pad[pidx] = pidx ? i_item.pad1_buttons : i_item.pad0_buttons;
                    end
                end
            end
            cbd_pkg::CMD_TICK: begin
                if (r_phase inside {cbd_pkg::PHASE_READ, cbd_pkg::PHASE_WRITE}) begin
                    if (r_running) begin
                        if (r_align) begin
                            // alignment ends on the odd slot
                            if (r_phase[0]) begin
                                n_align = 1'b0;
                            end
                        end else if (!r_phase[0]) begin
                            rd_en     = 1'b1;
                            rd_addr   = {r_page, r_index};
                            dma_fetch = 1'b1;
                        end else begin
                            o_res.oam_write = 1'b1;
                            o_res.oam_index = r_index;
                            o_res.oam_data  = r_byte;
                            n_index         = r_index + 8'd1;
                            if (r_index == cbd_pkg::DMA_LAST_IDX) begin
                                n_running = 1'b0;
                                n_align   = 1'b1;
                            end
                        end
                    end else begin
                        o_res.cpu_step = 1'b1;
                    end
                end
                o_res.cpu_nmi = i_item.ppu_nmi_request;
                n_phase = (r_phase == cbd_pkg::PHASE_LAST) ? 3'd0 : r_phase + 3'd1;
            end
            default: begin
            end
        endcase

        if (rd_en) begin
            if (i_item.cart_claims) begin
                rd_data = i_item.cart_read_data;
            end else if (rd_addr <= cbd_pkg::RAM_LAST_ADDR) begin
                // data arrives from the RAM in the next cycle
                o_ram.rd      = 1'b1;
                o_ram.addr    = rd_addr;
                o_res.ram_hit = 1'b1;
                n_cap         = dma_fetch;
            end else if (rd_addr <= cbd_pkg::PPU_LAST_ADDR) begin
                o_res.ppu_select   = 1'b1;
                o_res.ppu_register = rd_addr[2:0];
                rd_data            = i_item.ppu_read_data;
            end else if (rd_addr == cbd_pkg::PAD0_ADDR || rd_addr == cbd_pkg::PAD1_ADDR) begin
                rd_data          = {7'd0, r_pad[rd_addr[0]][7]};
                n_pad[rd_addr[0]] = {r_pad[rd_addr[0]][6:0], 1'b0};
            end
        end
        o_res.read_result = rd_data;
        if (dma_fetch && !o_res.ram_hit) begin
            n_byte = rd_data;
        end
        o_res.dma_active = n_running;
        o_res.dma_source = {n_page, n_index};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad[0]  <= '0;
            r_pad[1]  <= '0;
            r_page    <= '0;
            r_index   <= '0;
            r_byte    <= '0;
            r_running <= 1'b0;
            r_align   <= 1'b1;
            r_phase   <= '0;
            r_cap     <= 1'b0;
        end else begin
            r_cap <= i_fire && n_cap;
            if (i_fire) begin
                r_pad     <= n_pad;
                r_page    <= n_page;
                r_index   <= n_index;
                r_byte    <= n_byte;
                r_running <= n_running;
                r_align   <= n_align;
                r_phase   <= n_phase;
            end
            // a DMA byte fetched from work RAM lands here in the cycle after its beat
            if (r_cap) begin
                r_byte <= i_ram_rdata;
            end
        end
    end

endmodule
`default_nettype wire

### sv/cpu_bus_decode_oam_dma.sv
// CPU bus decoder with work RAM, pad ports and sprite DMA sequencing.
// Each beat is a CPU read, a CPU write or a system tick; one beat is taken per
// cycle when nothing stalls, and its result passes through an input register
// and a result register (work RAM read data is registered by the RAM and lands
// with the result). After reset a sweep zeroes all RAM_BYTES work RAM entries,
// during which the input channel stalls. While a result waits on a stalled
// output the core holds; the input register takes one more beat and then the
// input stalls, so full throughput holds whenever the output side does not stall.
`default_nettype none
module cpu_bus_decode_oam_dma #(
    parameter int RAM_BYTES = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    input  wire logic        i_peek_only,
    input  wire logic        i_cart_claims,
    input  wire logic [7:0]  i_cart_read_data,
    input  wire logic [7:0]  i_ppu_read_data,
    input  wire logic [7:0]  i_pad0_buttons,
    input  wire logic [7:0]  i_pad1_buttons,
    input  wire logic        i_ppu_nmi_request,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_read_result,
    output logic             o_ppu_select,
    output logic [2:0]       o_ppu_register,
    output logic             o_cpu_step,
    output logic             o_oam_write,
    output logic [7:0]       o_oam_index,
    output logic [7:0]       o_oam_data,
    output logic             o_dma_active_out,
    output logic [15:0]      o_dma_source,
    output logic             o_cpu_nmi
);

    localparam int AW = $clog2(RAM_BYTES);

    logic              r_s1_valid;
    cbd_pkg::t_item    r_s1;
    logic              r_s2_valid;
    cbd_pkg::t_result  r_s2;

    cbd_pkg::t_result  core_res;
    cbd_pkg::t_ram_req core_ram;
    logic              clr_busy;
    logic [AW-1:0]     clr_addr;
    logic [7:0]        ram_rdata;
    logic              adv;
    logic              accept;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;

    assign adv        = r_s1_valid && (!r_s2_valid || !i_out_stall);
    assign o_in_stall = clr_busy || (r_s1_valid && !adv);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_s2_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.command         <= i_command;
            r_s1.address         <= i_address;
            r_s1.write_data      <= i_write_data;
            r_s1.peek_only       <= i_peek_only;
            r_s1.cart_claims     <= i_cart_claims;
            r_s1.cart_read_data  <= i_cart_read_data;
            r_s1.ppu_read_data   <= i_ppu_read_data;
            r_s1.pad0_buttons    <= i_pad0_buttons;
            r_s1.pad1_buttons    <= i_pad1_buttons;
            r_s1.ppu_nmi_request <= i_ppu_nmi_request;
        end
        if (adv) begin
            r_s2 <= core_res;
        end
    end

    cbd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (adv),
        .i_item      (r_s1),
        .i_ram_rdata (ram_rdata),
        .o_res       (core_res),
        .o_ram       (core_ram)
    );

    cbd_clear #(
        .DEPTH (RAM_BYTES)
    ) u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (clr_busy),
        .o_addr  (clr_addr)
    );

    assign ram_we    = clr_busy || (adv && core_ram.wr);
    assign ram_waddr = clr_busy ? clr_addr : core_ram.addr[AW-1:0];
    assign ram_wdata = clr_busy ? 8'd0 : core_ram.wdata;

    cbd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (adv && core_ram.rd),
        .i_raddr (core_ram.addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid      = r_s2_valid;
    assign o_read_result    = r_s2.ram_hit ? ram_rdata : r_s2.read_result;
    assign o_ppu_select     = r_s2.ppu_select;
    assign o_ppu_register   = r_s2.ppu_register;
    assign o_cpu_step       = r_s2.cpu_step;
    assign o_oam_write      = r_s2.oam_write;
    assign o_oam_index      = r_s2.oam_index;
    assign o_oam_data       = r_s2.oam_data;
    assign o_dma_active_out = r_s2.dma_active;
    assign o_dma_source     = r_s2.dma_source;
    assign o_cpu_nmi        = r_s2.cpu_nmi;

`ifndef SYNTH
    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !r_s1_valid)
        else $error("beat in flight during RAM clear");

    a_no_core_write_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && core_ram.wr) |-> !clr_busy)
        else $error("core RAM write collides with clear sweep");

    a_step_excludes_oam: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cpu_step) |-> (!o_oam_write && !o_dma_active_out))
        else $error("CPU step issued while DMA owns the bus");

    a_oam_needs_dma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && core_res.oam_write) |-> !core_res.ram_hit)
        else $error("OAM write beat also reads work RAM");
`endif

endmodule
`default_nettype wire

### dv/cpu_bus_decode_oam_dma_tb.sv
// Self-checking bench for the CPU bus decoder: directed rows, then random beats vs a predictor.
`default_nettype none
module cpu_bus_decode_oam_dma_tb;
    import cbd_pkg::*;

    localparam int RAM_BYTES   = 2048;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RAND_BEATS  = 1450;
    localparam int HOLD_CYCLES = 60;
    localparam int IDLE_PCT    = 34;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]  rd;
        logic        psel;
        logic [2:0]  preg;
        logic        step;
        logic        oamw;
        logic [7:0]  oami;
        logic [7:0]  oamd;
        logic        act;
        logic [15:0] src;
        logic        nmi;
    } t_bus_outcome;

    typedef struct {
        t_item        it;
        bit           typed;
        t_bus_outcome val;
    } t_drow;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [15:0] i_address;
    logic [7:0]  i_write_data;
    logic        i_peek_only;
    logic        i_cart_claims;
    logic [7:0]  i_cart_read_data;
    logic [7:0]  i_ppu_read_data;
    logic [7:0]  i_pad0_buttons;
    logic [7:0]  i_pad1_buttons;
    logic        i_ppu_nmi_request;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_read_result;
    logic        o_ppu_select;
    logic [2:0]  o_ppu_register;
    logic        o_cpu_step;
    logic        o_oam_write;
    logic [7:0]  o_oam_index;
    logic [7:0]  o_oam_data;
    logic        o_dma_active_out;
    logic [15:0] o_dma_source;
    logic        o_cpu_nmi;

    cpu_bus_decode_oam_dma #(.RAM_BYTES(RAM_BYTES)) dut (.*);

    // shadow of the block state
    logic [7:0] mem_img [0:RAM_BYTES-1];
    logic [7:0] pad_sr [0:1];
    logic [7:0] dpage, didx, dbyte;
    logic       drun, dalign;
    logic [2:0] phase;
    int         dma_ends = 0;

    t_bus_outcome bus_outcome_q[$];
    t_drow        drows[$];
    int           mismatches = 0;
    int           cyc = 0;
    bit           calm = 0;
    bit           hold_start = 0;
    int           hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] bus_fetch(input logic [15:0] a, input t_item it,
                                             output logic psel, output logic [2:0] preg);
        logic [7:0] b;
        psel = 1'b0;
        preg = 3'd0;
        if (it.cart_claims)
            b = it.cart_read_data;
        else if (a <= RAM_LAST_ADDR)
            b = mem_img[int'(a) & (RAM_BYTES - 1)];
        else if (a <= PPU_LAST_ADDR) begin
            psel = 1'b1;
            preg = a[2:0];
            b = it.ppu_read_data;
        end else if (a == PAD0_ADDR || a == PAD1_ADDR) begin
            b = {7'd0, pad_sr[a[0]][7]};
            pad_sr[a[0]] = pad_sr[a[0]] << 1;
        end else
            b = 8'h00;
        return b;
    endfunction

    function automatic t_bus_outcome bus_outcome(input t_item it);
        t_bus_outcome o;
        logic         ps;
        logic [2:0]   pr;
        o = '0;
        case (it.command)
            CMD_READ: begin
                o.rd = bus_fetch(it.address, it, ps, pr);
                o.psel = ps;
                o.preg = pr;
            end
            CMD_WRITE: begin
                if (!it.cart_claims) begin
                    if (it.address <= RAM_LAST_ADDR)
                        mem_img[int'(it.address) & (RAM_BYTES - 1)] = it.write_data;
                    else if (it.address <= PPU_LAST_ADDR) begin
                        o.psel = 1'b1;
                        o.preg = it.address[2:0];
                    end else if (it.address == DMA_REG_ADDR) begin
                        // restart keeps the alignment state
                        dpage = it.write_data;
                        didx = 8'h00;
                        drun = 1'b1;
                    end else if (it.address == PAD0_ADDR || it.address == PAD1_ADDR)
                        pad_sr[it.address[0]] = it.address[0] ? it.pad1_buttons
                                                              : it.pad0_buttons;
                end
            end
            CMD_TICK: begin
                if (phase == PHASE_READ || phase == PHASE_WRITE) begin
                    if (!drun)
                        o.step = 1'b1;
                    else if (dalign) begin
                        if (phase == PHASE_WRITE)
                            dalign = 1'b0;
                    end else if (phase == PHASE_READ) begin
                        dbyte = bus_fetch({dpage, didx}, it, ps, pr);
                        o.rd = dbyte;
                        o.psel = ps;
                        o.preg = pr;
                    end else begin
                        o.oamw = 1'b1;
                        o.oami = didx;
                        o.oamd = dbyte;
                        if (didx == DMA_LAST_IDX) begin
                            drun = 1'b0;
                            dalign = 1'b1;
                            dma_ends++;
                        end
                        didx = didx + 8'd1;
                    end
                end
                o.nmi = it.ppu_nmi_request;
                phase = (phase == PHASE_LAST) ? 3'd0 : phase + 3'd1;
            end
            default: ;
        endcase
        o.act = drun;
        o.src = {dpage, didx};
        return o;
    endfunction

    function automatic t_item mk(input logic [1:0] cmd, input logic [15:0] a,
                                 input logic [7:0] d);
        t_item it;
        it.command = cmd;
        it.address = a;
        it.write_data = d;
        it.peek_only = $urandom_range(0, 1);
        it.cart_claims = 1'b0;
        it.cart_read_data = $urandom;
        it.ppu_read_data = $urandom;
        it.pad0_buttons = $urandom;
        it.pad1_buttons = $urandom;
        it.ppu_nmi_request = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic logic [7:0] pick_page();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 8'h1F));
            1: return 8'($urandom_range(8'h20, 8'h3F));
            2: return 8'h40;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void check_field(input string tag, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t %s: expected %0h, actual %0h", $time, tag, want, got);
            mismatches++;
        end
    endfunction

    task automatic add_row(input t_item it, input bit typed, input t_bus_outcome v);
        drows.push_back('{it, typed, v});
    endtask

    task automatic idle_gap();
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic offer(input t_item it);
        i_in_valid <= 1'b1;
        i_command <= it.command;
        i_address <= it.address;
        i_write_data <= it.write_data;
        i_peek_only <= it.peek_only;
        i_cart_claims <= it.cart_claims;
        i_cart_read_data <= it.cart_read_data;
        i_ppu_read_data <= it.ppu_read_data;
        i_pad0_buttons <= it.pad0_buttons;
        i_pad1_buttons <= it.pad1_buttons;
        i_ppu_nmi_request <= it.ppu_nmi_request;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cyc++;
        if (cyc >= CYCLE_LIMIT) begin
            $display("cpu_bus_decode_oam_dma_tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left = HOLD_CYCLES;
            hold_start = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else
            i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin : result_check
        t_bus_outcome head;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (bus_outcome_q.size() == 0) begin
                $display("%0t surplus beat: expected none, actual read_result %0h",
                         $time, o_read_result);
                mismatches++;
            end else begin
                head = bus_outcome_q.pop_front();
                check_field("read_result", head.rd, o_read_result);
                check_field("ppu_select", head.psel, o_ppu_select);
                check_field("ppu_register", head.preg, o_ppu_register);
                check_field("cpu_step", head.step, o_cpu_step);
                check_field("oam_write", head.oamw, o_oam_write);
                check_field("oam_index", head.oami, o_oam_index);
                check_field("oam_data", head.oamd, o_oam_data);
                check_field("dma_active_out", head.act, o_dma_active_out);
                check_field("dma_source", head.src, o_dma_source);
                check_field("cpu_nmi", head.nmi, o_cpu_nmi);
            end
        end
    end

    initial begin
        t_item        it;
        t_bus_outcome zero, tick_step, pred;
        int           n, r, ra;

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_command <= CMD_READ;
        i_address <= 16'h0000;
        i_write_data <= 8'h00;
        i_peek_only <= 1'b0;
        i_cart_claims <= 1'b0;
        i_cart_read_data <= 8'h00;
        i_ppu_read_data <= 8'h00;
        i_pad0_buttons <= 8'h00;
        i_pad1_buttons <= 8'h00;
        i_ppu_nmi_request <= 1'b0;

        for (n = 0; n < RAM_BYTES; n++)
            mem_img[n] = 8'h00;
        pad_sr[0] = 8'h00;
        pad_sr[1] = 8'h00;
        dpage = 8'h00;
        didx = 8'h00;
        dbyte = 8'h00;
        drun = 1'b0;
        dalign = 1'b1;
        phase = 3'd0;

        zero = '0;
        tick_step = '0;
        tick_step.step = 1'b1;
        tick_step.nmi = 1'b1;

        // rows typed in by hand first: nothing has touched RAM or DMA yet
        add_row(mk(CMD_READ, 16'h0000, 8'h00), 1, zero);
        add_row(mk(CMD_READ, 16'h4015, 8'h00), 1, zero);
        add_row(mk(CMD_READ, DMA_REG_ADDR, 8'h00), 1, zero);
        add_row(mk(CMD_UNUSED, DMA_REG_ADDR, 8'hFF), 1, zero);
        it = mk(CMD_TICK, 16'hFFFF, 8'hFF);
        it.ppu_nmi_request = 1'b1;
        add_row(it, 1, tick_step);
        add_row(mk(CMD_READ, 16'hFFFF, 8'h00), 1, zero);
        add_row(mk(CMD_WRITE, 16'h4000, 8'hFF), 1, zero);
        add_row(mk(CMD_WRITE, 16'h0000, 8'hFF), 1, zero);
        add_row(mk(CMD_WRITE, RAM_LAST_ADDR, 8'h5A), 0, zero);
        add_row(mk(CMD_READ, 16'h07FF, 8'h00), 0, zero);
        add_row(mk(CMD_READ, 16'h0800, 8'h00), 0, zero);
        add_row(mk(CMD_WRITE, 16'h2000, 8'h00), 0, zero);
        it = mk(CMD_READ, PPU_LAST_ADDR, 8'h00);
        it.ppu_read_data = 8'hFF;
        it.peek_only = 1'b1;
        add_row(it, 0, zero);
        it = mk(CMD_READ, 16'h1234, 8'h00);
        it.cart_claims = 1'b1;
        add_row(it, 0, zero);
        it = mk(CMD_WRITE, DMA_REG_ADDR, 8'h12);
        it.cart_claims = 1'b1;
        add_row(it, 0, zero);
        it = mk(CMD_WRITE, PAD0_ADDR, 8'h00);
        it.pad0_buttons = 8'h80;
        add_row(it, 0, zero);
        it = mk(CMD_READ, PAD0_ADDR, 8'h00);
        it.peek_only = 1'b1;
        add_row(it, 0, zero);
        add_row(mk(CMD_READ, PAD0_ADDR, 8'h00), 0, zero);
        it = mk(CMD_WRITE, PAD1_ADDR, 8'h00);
        it.pad1_buttons = 8'hFF;
        add_row(it, 0, zero);
        add_row(mk(CMD_READ, PAD1_ADDR, 8'h00), 0, zero);
        add_row(mk(CMD_WRITE, DMA_REG_ADDR, 8'h07), 0, zero);
        repeat (3) add_row(mk(CMD_TICK, 16'h0000, 8'h00), 0, zero);
        // restart from the I/O page so the source walks over the pad ports
        add_row(mk(CMD_WRITE, DMA_REG_ADDR, 8'h40), 0, zero);
        add_row(mk(CMD_TICK, 16'h0000, 8'h00), 0, zero);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (drows[k]) begin
            idle_gap();
            offer(drows[k].it);
            pred = bus_outcome(drows[k].it);
            bus_outcome_q.push_back(drows[k].typed ? drows[k].val : pred);
        end

        n = 0;
        while (n < RAND_BEATS || dma_ends == 0) begin
            if (n == 200)
                hold_start = 1;
            if (n == 500) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (bus_outcome_q.size() != 0);
            end
            calm = (n >= 800 && n < 1100);
            idle_gap();

            r = $urandom_range(0, 99);
            it = mk(CMD_TICK, 16'($urandom), 8'($urandom));
            it.cart_claims = ($urandom_range(0, 7) == 0);
            if ((drun && r < 95) || (!drun && r < 40)) begin
                // tick: the DMA engine only advances on these
            end else if (!drun && r < 45) begin
                it.command = CMD_WRITE;
                it.address = DMA_REG_ADDR;
                it.cart_claims = 1'b0;
                it.write_data = pick_page();
            end else begin
                if ($urandom_range(0, 99) == 0)
                    it.command = CMD_UNUSED;
                else
                    it.command = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
                ra = $urandom_range(0, 19);
                if (ra < 8)
                    it.address = 16'($urandom_range(0, RAM_LAST_ADDR));
                else if (ra < 12)
                    it.address = 16'($urandom_range(16'h2000, PPU_LAST_ADDR));
                else if (ra < 15)
                    it.address = $urandom_range(0, 1) ? PAD1_ADDR : PAD0_ADDR;
                else if (ra < 17)
                    it.address = 16'($urandom_range(16'h4000, 16'h401F));
                else
                    it.address = 16'($urandom);
            end
            offer(it);
            bus_outcome_q.push_back(bus_outcome(it));
            n++;
        end
        calm = 0;

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (bus_outcome_q.size() != 0);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("cpu_bus_decode_oam_dma_tb: clean");
        else
            $display("cpu_bus_decode_oam_dma_tb: errors");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
sv/cbd_pkg.sv
sv/cbd_ram.sv
sv/cbd_clear.sv
sv/cbd_core.sv
sv/cpu_bus_decode_oam_dma.sv
dv/cpu_bus_decode_oam_dma_tb.sv
